/* hw/rtl/fbit_pkg.sv */
package fbit_pkg;

    // field widths
    localparam int unsigned DUR_W  = 31;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned MIN_W  = 16;
    localparam int unsigned SEC_W  = 6;
    localparam int unsigned TOT_W  = 22;   // whole seconds of a 31-bit ms value, rounded up
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 32;

    // default zero-hold before the phase flips
    localparam int unsigned HOLD_MS_DEF = 1000;

    // register reset values
    localparam logic [DUR_W-1:0] FOCUS_RST = 31'd1500000;
    localparam logic [DUR_W-1:0] BREAK_RST = 31'd300000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK = 4'd1;

    // ms to seconds, rounded up: (x + 999) / 1000 by reciprocal
    localparam logic [TIME_W-1:0] ROUND_UP_MS    = 32'd999;
    localparam logic [28:0]       DIV1000_MAGIC  = 29'd274877907;
    localparam int unsigned       DIV1000_SHIFT  = 38;
    localparam int unsigned       PROD1_W        = TIME_W + 29;

    // seconds to minutes by reciprocal
    localparam logic [31:0]       DIV60_MAGIC    = 32'd2290649225;
    localparam int unsigned       DIV60_SHIFT    = 37;
    localparam int unsigned       PROD2_W        = TOT_W + 32;
    localparam logic [TOT_W-1:0]  SECS_PER_MIN   = 22'd60;

    typedef enum logic [2:0] {
        REQ_BEGIN   = 3'd0,
        REQ_TICK    = 3'd1,
        REQ_PAUSE   = 3'd2,
        REQ_RESET   = 3'd3,
        REQ_SKIP    = 3'd4,
        REQ_FRZ_ON  = 3'd5,
        REQ_FRZ_OFF = 3'd6
    } t_req;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [TIME_W-1:0] now_ms;
        logic              compensate;
    } t_in_item;

    typedef struct packed {
        logic [DUR_W-1:0] remaining_ms;
        logic [MIN_W-1:0] minutes;
        logic [SEC_W-1:0] seconds;
        logic             phase;
        logic             paused;
        logic             frozen;
        logic             phase_ended;
    } t_out_item;

    // timer state after one item, handed to the formatter
    typedef struct packed {
        logic [DUR_W-1:0] remaining;
        logic             phase;
        logic             paused;
        logic             frozen;
        logic             ended;
    } t_snap;

endpackage

/* hw/rtl/focus_break_interval_timer_unit.sv */
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------------------
// in        | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
// out       | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
// cfg       | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled
// a result passes the timer state register, then a register after each of the ms-to-seconds
//   and seconds-to-minutes reciprocal multiplies, then the output register
// synchronous active-low reset: timer paused at zero, durations at 25 and 5 minutes
// a stalled output backs up stage by stage; o_in_ready drops only when all four are full
// config writes are always taken
module focus_break_interval_timer_unit #(
    parameter int unsigned HOLD_MS = fbit_pkg::HOLD_MS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [fbit_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbit_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_cfg_ready,
    input  logic                               i_in_valid,
    input  fbit_pkg::t_in_item                 i_in_item,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    output fbit_pkg::t_out_item                o_out_item,
    input  logic                               i_out_ready
);

    // timer state to formatter
    logic            snap_valid;
    logic            snap_ready;
    fbit_pkg::t_snap snap;

    // event decode and timer state, also the first pipeline stage
    fbit_core #(
        .HOLD_MS (HOLD_MS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_ready   (o_in_ready),
        .o_snap_valid (snap_valid),
        .o_snap       (snap),
        .i_snap_ready (snap_ready)
    );

    // minutes / seconds split, three stages with the output register last
    fbit_fmt u_fmt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_snap_ready (snap_ready),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_ready  (i_out_ready)
    );

    // display reads zero exactly when no time is left
    a_zero_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_item.minutes == '0 && o_out_item.seconds == '0) ==
             (o_out_item.remaining_ms == '0)))
        else $error("display and remaining time disagree");

    // seconds field stays within a minute
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.seconds < 6'd60))
        else $error("seconds out of range");

    // the zero-hold always shows zero remaining
    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.phase_ended) |-> (o_out_item.remaining_ms == '0))
        else $error("remaining time nonzero during hold");

    // nothing comes out in the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present right after reset");

endmodule

/* hw/rtl/fbit_core.sv */
module fbit_core #(
    parameter int unsigned HOLD_MS = fbit_pkg::HOLD_MS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [fbit_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbit_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_cfg_ready,
    input  logic                               i_in_valid,
    input  fbit_pkg::t_in_item                 i_in_item,
    output logic                               o_in_ready,
    output logic                               o_snap_valid,
    output fbit_pkg::t_snap                    o_snap,
    input  logic                               i_snap_ready
);

    localparam int unsigned DW = fbit_pkg::DUR_W;
    localparam int unsigned TW = fbit_pkg::TIME_W;
    localparam logic [TW-1:0] HOLD = TW'(HOLD_MS);

    logic [DW-1:0] r_focus, r_break;
    logic [TW-1:0] r_start, n_start;
    logic [DW-1:0] r_rem, n_rem;
    logic          r_phase, n_phase;
    logic          r_paused, n_paused;
    logic [TW-1:0] r_end, n_end;
    logic          r_ended, n_ended;
    logic [TW-1:0] r_pmark, n_pmark;
    logic          r_frz, n_frz;
    logic          r_refund, n_refund;
    logic [TW-1:0] r_fmark, n_fmark;
    logic          r_v1;

    logic          acc;
    logic [TW-1:0] now;
    logic [TW-1:0] elapsed, d_pause, d_frz;
    logic [DW-1:0] cur_len, alt_len;
    logic          run_done, hold_gone;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_v1 || i_snap_ready;
    assign acc         = i_in_valid && o_in_ready;
    assign now         = i_in_item.now_ms;

    always_comb begin
        n_start  = r_start;
        n_rem    = r_rem;
        n_phase  = r_phase;
        n_paused = r_paused;
        n_end    = r_end;
        n_ended  = r_ended;
        n_pmark  = r_pmark;
        n_frz    = r_frz;
        n_refund = r_refund;
        n_fmark  = r_fmark;

        cur_len   = r_phase ? r_break : r_focus;
        alt_len   = r_phase ? r_focus : r_break;
        elapsed   = now - r_start;
        run_done  = elapsed >= {1'b0, cur_len};
        hold_gone = (now - r_end) >= HOLD;
        d_pause   = now - r_pmark;
        d_frz     = now - r_fmark;

        unique case (fbit_pkg::t_req'(i_in_item.req_type))
            fbit_pkg::REQ_BEGIN: begin
                n_start  = now;
                n_rem    = r_focus;
                n_phase  = 1'b0;
                n_paused = 1'b0;
                n_end    = '0;
                n_ended  = 1'b0;
                n_pmark  = '0;
                n_frz    = 1'b0;
                n_refund = 1'b0;
                n_fmark  = '0;
            end
            fbit_pkg::REQ_TICK: begin
                if (!r_paused && !r_frz) begin
                    if (r_ended) begin
                        if (hold_gone) begin
                            // elapsed is zero in the new phase
                            n_phase = !r_phase;
                            n_start = now;
                            n_rem   = alt_len;
                            n_ended = 1'b0;
                        end
                    end else if (run_done) begin
                        n_rem   = '0;
                        n_end   = now;
                        n_ended = 1'b1;
                    end else begin
                        n_rem = DW'({1'b0, cur_len} - elapsed);
                    end
                end
            end
            fbit_pkg::REQ_PAUSE: begin
                if (!r_paused) begin
                    n_pmark  = now;
                    n_paused = 1'b1;
                end else begin
                    n_start  = r_start + d_pause;
                    if (r_ended) begin
                        n_end = r_end + d_pause;
                    end
                    n_paused = 1'b0;
                end
            end
            fbit_pkg::REQ_RESET: begin
                n_start = now;
                n_rem   = cur_len;
                n_ended = 1'b0;
                n_end   = '0;
                if (r_paused) begin
                    n_pmark = now;
                end
            end
            fbit_pkg::REQ_SKIP: begin
                n_phase = !r_phase;
                n_start = now;
                n_rem   = alt_len;
                n_ended = 1'b0;
                n_end   = '0;
                if (r_paused) begin
                    n_pmark = now;
                end
            end
            fbit_pkg::REQ_FRZ_ON: begin
                if (!r_frz) begin
                    n_frz    = 1'b1;
                    n_fmark  = now;
                    n_refund = !r_paused;
                end
            end
            fbit_pkg::REQ_FRZ_OFF: begin
                if (r_frz) begin
                    if (i_in_item.compensate && r_refund) begin
                        n_start = r_start + d_frz;
                        if (r_ended) begin
                            n_end = r_end + d_frz;
                        end
                    end
                    n_frz    = 1'b0;
                    n_fmark  = '0;
                    n_refund = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus  <= fbit_pkg::FOCUS_RST;
            r_break  <= fbit_pkg::BREAK_RST;
            r_start  <= '0;
            r_rem    <= '0;
            r_phase  <= 1'b0;
            r_paused <= 1'b1;
            r_end    <= '0;
            r_ended  <= 1'b0;
            r_pmark  <= '0;
            r_frz    <= 1'b0;
            r_refund <= 1'b0;
            r_fmark  <= '0;
            r_v1     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fbit_pkg::CFG_FOCUS: r_focus <= i_cfg_data[DW-1:0];
                    fbit_pkg::CFG_BREAK: r_break <= i_cfg_data[DW-1:0];
                    default: begin
                    end
                endcase
            end
            if (acc) begin
                r_start  <= n_start;
                r_rem    <= n_rem;
                r_phase  <= n_phase;
                r_paused <= n_paused;
                r_end    <= n_end;
                r_ended  <= n_ended;
                r_pmark  <= n_pmark;
                r_frz    <= n_frz;
                r_refund <= n_refund;
                r_fmark  <= n_fmark;
                r_v1     <= 1'b1;
            end else if (i_snap_ready) begin
                r_v1 <= 1'b0;
            end
        end
    end

    // the state registers double as the first stage: they only move when it drains
    assign o_snap_valid     = r_v1;
    assign o_snap.remaining = r_rem;
    assign o_snap.phase     = r_phase;
    assign o_snap.paused    = r_paused;
    assign o_snap.frozen    = r_frz;
    assign o_snap.ended     = r_ended;

endmodule

/* hw/rtl/fbit_fmt.sv */
module fbit_fmt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_snap_valid,
    input  fbit_pkg::t_snap     i_snap,
    output logic                o_snap_ready,
    output logic                o_out_valid,
    output fbit_pkg::t_out_item o_out_item,
    input  logic                i_out_ready
);

    localparam int unsigned TOT_W = fbit_pkg::TOT_W;
    localparam int unsigned MIN_W = fbit_pkg::MIN_W;
    localparam int unsigned SEC_W = fbit_pkg::SEC_W;
    localparam int unsigned P1_W  = fbit_pkg::PROD1_W;
    localparam int unsigned P2_W  = fbit_pkg::PROD2_W;

    logic                r_v2, r_v3, r_v4;
    logic                rdy2, rdy3, rdy4;
    fbit_pkg::t_snap     r_snap2, r_snap3;
    logic [TOT_W-1:0]    r_tot2, r_tot3;
    logic [MIN_W-1:0]    r_min3;
    fbit_pkg::t_out_item r_out;

    logic [fbit_pkg::TIME_W-1:0] ms_up;
    logic [P1_W-1:0]             prod1;
    logic [P2_W-1:0]             prod2;
    logic [TOT_W-1:0]            sec_full;

    assign rdy4         = !r_v4 || i_out_ready;
    assign rdy3         = !r_v3 || rdy4;
    assign rdy2         = !r_v2 || rdy3;
    assign o_snap_ready = rdy2;

    // ceil to whole seconds
    assign ms_up = {1'b0, i_snap.remaining} + fbit_pkg::ROUND_UP_MS;
    assign prod1 = P1_W'(ms_up) * P1_W'(fbit_pkg::DIV1000_MAGIC);
    // split into minutes
    assign prod2 = P2_W'(r_tot2) * P2_W'(fbit_pkg::DIV60_MAGIC);
    assign sec_full = r_tot3 - TOT_W'(r_min3) * fbit_pkg::SECS_PER_MIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy2) r_v2 <= i_snap_valid;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_snap_valid) begin
            r_snap2 <= i_snap;
            r_tot2  <= prod1[fbit_pkg::DIV1000_SHIFT +: TOT_W];
        end
        if (rdy3 && r_v2) begin
            r_snap3 <= r_snap2;
            r_tot3  <= r_tot2;
            r_min3  <= prod2[fbit_pkg::DIV60_SHIFT +: MIN_W];
        end
        if (rdy4 && r_v3) begin
            r_out.remaining_ms <= r_snap3.remaining;
            r_out.minutes      <= r_min3;
            r_out.seconds      <= sec_full[SEC_W-1:0];
            r_out.phase        <= r_snap3.phase;
            r_out.paused       <= r_snap3.paused;
            r_out.frozen       <= r_snap3.frozen;
            r_out.phase_ended  <= r_snap3.ended;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_item  = r_out;

endmodule

/* verif/fbit_timer_checker.sv */
module fbit_timer_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [fbit_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbit_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  fbit_pkg::t_in_item               i_in_item,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  fbit_pkg::t_out_item              i_out_item,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DUR_W       = fbit_pkg::DUR_W;
    localparam int unsigned MIN_W       = fbit_pkg::MIN_W;
    localparam int unsigned SEC_W       = fbit_pkg::SEC_W;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [31:0] HOLD_LEN    = fbit_pkg::HOLD_MS_DEF;
    localparam longint unsigned MS_PER_SEC  = 1000;
    localparam longint unsigned SEC_PER_MIN = 60;

    // predicted timer state
    logic [DUR_W-1:0] focus_len, break_len;
    logic [31:0]      start_mark, remaining, end_mark, pause_mark, freeze_mark;
    logic             phase, paused, ended, frozen, refund;

    fbit_pkg::t_out_item status_q[$];
    fbit_pkg::t_out_item want;
    int                  mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic clear_timer();
        focus_len   = fbit_pkg::FOCUS_RST;
        break_len   = fbit_pkg::BREAK_RST;
        start_mark  = '0;
        remaining   = '0;
        phase       = 1'b0;
        paused      = 1'b1;
        end_mark    = '0;
        ended       = 1'b0;
        pause_mark  = '0;
        frozen      = 1'b0;
        refund      = 1'b0;
        freeze_mark = '0;
    endtask

    function automatic logic [31:0] phase_len();
        return phase ? {1'b0, break_len} : {1'b0, focus_len};
    endfunction

    // time left at now_t, run_out set once the phase has expired
    function automatic logic [31:0] time_to_go(input logic [31:0] now_t, output logic run_out);
        logic [31:0] gone;
        gone    = now_t - start_mark;
        run_out = (gone >= phase_len());
        return run_out ? 32'd0 : phase_len() - gone;
    endfunction

    task automatic slip_marks(input logic [31:0] delta);
        start_mark += delta;
        if (ended) begin
            end_mark += delta;
        end
    endtask

    task automatic restart_phase(input logic [31:0] now_t);
        start_mark = now_t;
        remaining  = phase_len();
        ended      = 1'b0;
        end_mark   = '0;
        if (paused) begin
            pause_mark = now_t;
        end
    endtask

    task automatic advance_timer(input fbit_pkg::t_in_item it);
        logic run_out;
        case (it.req_type)
            fbit_pkg::REQ_BEGIN: begin
                start_mark  = it.now_ms;
                remaining   = {1'b0, focus_len};
                phase       = 1'b0;
                paused      = 1'b0;
                end_mark    = '0;
                ended       = 1'b0;
                pause_mark  = '0;
                frozen      = 1'b0;
                refund      = 1'b0;
                freeze_mark = '0;
            end
            fbit_pkg::REQ_TICK: begin
                if (!paused && !frozen) begin
                    if (ended) begin
                        if (it.now_ms - end_mark >= HOLD_LEN) begin
                            phase      = ~phase;
                            start_mark = it.now_ms;
                            remaining  = time_to_go(it.now_ms, run_out);
                            ended      = 1'b0;
                        end
                    end else begin
                        remaining = time_to_go(it.now_ms, run_out);
                        if (run_out) begin
                            end_mark = it.now_ms;
                            ended    = 1'b1;
                        end
                    end
                end
            end
            fbit_pkg::REQ_PAUSE: begin
                if (!paused) begin
                    pause_mark = it.now_ms;
                    paused     = 1'b1;
                end else begin
                    slip_marks(it.now_ms - pause_mark);
                    paused = 1'b0;
                end
            end
            fbit_pkg::REQ_RESET: begin
                restart_phase(it.now_ms);
            end
            fbit_pkg::REQ_SKIP: begin
                phase = ~phase;
                restart_phase(it.now_ms);
            end
            fbit_pkg::REQ_FRZ_ON: begin
                if (!frozen) begin
                    frozen      = 1'b1;
                    freeze_mark = it.now_ms;
                    refund      = ~paused;
                end
            end
            fbit_pkg::REQ_FRZ_OFF: begin
                if (frozen) begin
                    if (it.compensate && refund) begin
                        slip_marks(it.now_ms - freeze_mark);
                    end
                    frozen      = 1'b0;
                    freeze_mark = '0;
                    refund      = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic fbit_pkg::t_out_item timer_status();
        fbit_pkg::t_out_item s;
        longint unsigned     secs;
        secs           = (longint'(remaining) + MS_PER_SEC - 1) / MS_PER_SEC;
        s.remaining_ms = remaining[DUR_W-1:0];
        s.minutes      = MIN_W'(secs / SEC_PER_MIN);
        s.seconds      = SEC_W'(secs % SEC_PER_MIN);
        s.phase        = phase;
        s.paused       = paused;
        s.frozen       = frozen;
        s.phase_ended  = ended;
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_timer();
            status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == fbit_pkg::CFG_FOCUS) begin
                    focus_len = i_cfg_data[DUR_W-1:0];
                end else if (i_cfg_index == fbit_pkg::CFG_BREAK) begin
                    break_len = i_cfg_data[DUR_W-1:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result at %0t: rem=%0d min=%0d sec=%0d %b%b%b%b",
                                 $time, i_out_item.remaining_ms, i_out_item.minutes,
                                 i_out_item.seconds, i_out_item.phase, i_out_item.paused,
                                 i_out_item.frozen, i_out_item.phase_ended);
                    end
                end else begin
                    want = status_q.pop_front();
                    if (i_out_item.remaining_ms !== want.remaining_ms ||
                        i_out_item.minutes      !== want.minutes      ||
                        i_out_item.seconds      !== want.seconds      ||
                        i_out_item.phase        !== want.phase        ||
                        i_out_item.paused       !== want.paused       ||
                        i_out_item.frozen       !== want.frozen       ||
                        i_out_item.phase_ended  !== want.phase_ended) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch at %0t (phase/paused/frozen/ended)", $time);
                            $display("  expected rem=%0d min=%0d sec=%0d %b%b%b%b",
                                     want.remaining_ms, want.minutes, want.seconds,
                                     want.phase, want.paused, want.frozen, want.phase_ended);
                            $display("  got      rem=%0d min=%0d sec=%0d %b%b%b%b",
                                     i_out_item.remaining_ms, i_out_item.minutes,
                                     i_out_item.seconds, i_out_item.phase, i_out_item.paused,
                                     i_out_item.frozen, i_out_item.phase_ended);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_timer(i_in_item);
                status_q.push_back(timer_status());
            end
        end
        o_outstanding = status_q.size();
    end

endmodule

/* verif/tb_focus_break_interval_timer_unit.sv */
module tb_focus_break_interval_timer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int          SEGMENTS       = 9;
    localparam int          SEGMENT_ITEMS  = 183;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam logic [2:0]  REQ_UNKNOWN    = 3'd7;
    localparam logic [fbit_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'hF;
    localparam logic [31:0] DUR_MAX        = 32'h7FFF_FFFF;
    localparam longint      STEP_CAP       = 64'h3FFF_FFFF;
    localparam int unsigned DUR_W          = fbit_pkg::DUR_W;

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [fbit_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [fbit_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                            o_cfg_ready;
    logic                            i_in_valid  = 1'b0;
    fbit_pkg::t_in_item              i_in_item   = '0;
    logic                            o_in_ready;
    logic                            o_out_valid;
    fbit_pkg::t_out_item             o_out_item;
    logic                            i_out_ready = 1'b0;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles  = 0;
    int          mismatches;
    int          outstanding;
    logic [31:0] clock_ms;       // running wall-clock time of the event stream
    int unsigned step_max;       // largest time advance between events

    focus_break_interval_timer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready)
    );

    // prediction and comparison live in the checker
    fbit_timer_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_item    (o_out_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls at random, one decision per cycle
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog: ends the run when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one item on the event channel, entered and left at a falling edge
    task automatic send_event(input logic [2:0] req, input logic [31:0] now_t,
                              input logic comp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        i_in_item.req_type   = req;
        i_in_item.now_ms     = now_t;
        i_in_item.compensate = comp;
        i_in_valid           = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [fbit_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // durations change only once every result is back
    task automatic set_durations(input logic [31:0] focus_ms, input logic [31:0] break_ms);
        longint span;
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        write_reg(fbit_pkg::CFG_FOCUS, focus_ms);
        write_reg(fbit_pkg::CFG_BREAK, break_ms);
        // time steps scale with the phases so that holds and flips are reached
        span     = (longint'(focus_ms[DUR_W-1:0]) + longint'(break_ms[DUR_W-1:0])) / 6 + 1500;
        step_max = (span > STEP_CAP) ? int'(STEP_CAP) : int'(span);
    endtask

    // mostly ticks on a running clock, with every other event mixed in
    task automatic random_event();
        int          pick;
        logic [2:0]  req;
        logic [31:0] now_t;
        pick     = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, step_max);
        now_t    = clock_ms;
        if (pick < 4) begin
            req = fbit_pkg::REQ_BEGIN;
        end else if (pick < 56) begin
            req = fbit_pkg::REQ_TICK;
        end else if (pick < 64) begin
            req = fbit_pkg::REQ_PAUSE;
        end else if (pick < 68) begin
            req = fbit_pkg::REQ_RESET;
        end else if (pick < 74) begin
            req = fbit_pkg::REQ_SKIP;
        end else if (pick < 82) begin
            req = fbit_pkg::REQ_FRZ_ON;
        end else if (pick < 90) begin
            req = fbit_pkg::REQ_FRZ_OFF;
        end else if (pick < 92) begin
            req = REQ_UNKNOWN;
        end else begin
            // noise: any request at an arbitrary time, sometimes the clock jumps there
            req   = 3'($urandom_range(0, 7));
            now_t = $urandom();
            if ($urandom_range(0, 1) == 1) begin
                clock_ms = now_t;
            end
        end
        send_event(req, now_t, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        send_idle_pct = 32;
        recv_idle_pct = 73;
        step_max      = 3000;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset state, unknown request, time extremes and wrap
        send_event(fbit_pkg::REQ_TICK, 32'd0, 1'b0);
        send_event(REQ_UNKNOWN, 32'hFFFF_FFFF, 1'b1);
        send_event(fbit_pkg::REQ_PAUSE, 32'd100, 1'b0);
        clock_ms = 32'hFFFF_F000;
        send_event(fbit_pkg::REQ_BEGIN, clock_ms, 1'b0);
        clock_ms += 600000;
        send_event(fbit_pkg::REQ_TICK, clock_ms, 1'b0);
        // freeze, repeated freeze, tick while frozen, pause toggles while frozen
        clock_ms += 100000;
        send_event(fbit_pkg::REQ_FRZ_ON, clock_ms, 1'b0);
        clock_ms += 50;
        send_event(fbit_pkg::REQ_FRZ_ON, clock_ms, 1'b1);
        clock_ms += 5000;
        send_event(fbit_pkg::REQ_TICK, clock_ms, 1'b0);
        clock_ms += 100;
        send_event(fbit_pkg::REQ_PAUSE, clock_ms, 1'b0);
        clock_ms += 200;
        send_event(fbit_pkg::REQ_PAUSE, clock_ms, 1'b0);
        // freeze end with refund, then a freeze end while not frozen
        clock_ms += 20000;
        send_event(fbit_pkg::REQ_FRZ_OFF, clock_ms, 1'b1);
        clock_ms += 10;
        send_event(fbit_pkg::REQ_FRZ_OFF, clock_ms, 1'b1);
        // run past the end, pause inside the zero-hold, then flip
        clock_ms += 2000000;
        send_event(fbit_pkg::REQ_TICK, clock_ms, 1'b0);
        clock_ms += 400;
        send_event(fbit_pkg::REQ_TICK, clock_ms, 1'b0);
        clock_ms += 100;
        send_event(fbit_pkg::REQ_PAUSE, clock_ms, 1'b0);
        clock_ms += 3000;
        send_event(fbit_pkg::REQ_PAUSE, clock_ms, 1'b0);
        clock_ms += 700;
        send_event(fbit_pkg::REQ_TICK, clock_ms, 1'b0);
        clock_ms += 5000;
        send_event(fbit_pkg::REQ_SKIP, clock_ms, 1'b0);
        clock_ms += 10;
        send_event(fbit_pkg::REQ_RESET, clock_ms, 1'b0);
        // freeze while paused gives nothing back, skip while paused moves the pause mark
        clock_ms += 1000;
        send_event(fbit_pkg::REQ_PAUSE, clock_ms, 1'b0);
        clock_ms += 1000;
        send_event(fbit_pkg::REQ_FRZ_ON, clock_ms, 1'b0);
        clock_ms += 9000;
        send_event(fbit_pkg::REQ_FRZ_OFF, clock_ms, 1'b1);
        clock_ms += 500;
        send_event(fbit_pkg::REQ_SKIP, clock_ms, 1'b0);
        clock_ms += 4000;
        send_event(fbit_pkg::REQ_PAUSE, clock_ms, 1'b0);
        clock_ms += 60000;
        send_event(fbit_pkg::REQ_TICK, clock_ms, 1'b0);

        // random part: each segment its own durations, idling shifts every three
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            send_idle_pct = (seg < 3) ? 32 : (seg < 6) ? 73 : 0;
            recv_idle_pct = (seg < 3) ? 73 : (seg < 6) ? 32 : 0;
            case (seg)
                1: set_durations(32'd0, $urandom_range(1, 2000));
                2: begin
                    // top bit of the data is dropped, unused index is harmless
                    set_durations(32'hFFFF_FFFF, 32'd0);
                    write_reg(CFG_UNUSED, $urandom());
                end
                3: set_durations(32'(fbit_pkg::FOCUS_RST), 32'(fbit_pkg::BREAK_RST));
                5: set_durations(32'd1, DUR_MAX);
                7: set_durations($urandom(), $urandom());
                default: set_durations($urandom_range(1000, 6000), $urandom_range(500, 3000));
            endcase
            send_event(fbit_pkg::REQ_BEGIN, clock_ms, 1'($urandom_range(0, 1)));
            repeat (SEGMENT_ITEMS) random_event();
        end

        // drain, then let anything stray come out before the verdict
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
